>>> rtl/core/salc_pkg.sv
`default_nettype none

package salc_pkg;

    localparam int MAX_SET_BITS = 6;
    localparam int WAYS = 4;
    localparam int ADDR_W = 64;

    localparam int SET_COUNT = 1 << MAX_SET_BITS;
    localparam int SET_W = MAX_SET_BITS;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAY_CNT_W = $clog2(WAYS + 1);
    localparam int TAG_W = 63;
    localparam int RANK_W = WAY_W;
    localparam int CNT_W = 32;
    localparam int SHIFT_W = 7;

    localparam int KIND_W = 2;
    localparam int SET_BITS_W = 3;
    localparam int BLOCK_BITS_W = 6;
    localparam int WAYS_CFG_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [KIND_W-1:0] KIND_ACCESS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd1;

    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS = 2'd2;

    typedef logic [TAG_W-1:0] tag_t;
    typedef logic [RANK_W-1:0] rank_t;
    typedef logic [WAY_W-1:0] way_t;
    typedef logic [WAYS-1:0] way_mask_t;

    localparam rank_t RANK_MAX = rank_t'(WAYS - 1);

    typedef struct packed {
        tag_t [WAYS-1:0]  tags;
        rank_t [WAYS-1:0] ranks;
    } row_t;

    typedef struct packed {
        logic done;
        logic hit;
        way_t hit_way;
        logic free_found;
        way_t free_way;
        way_t victim_way;
    } scan_res_t;

endpackage

`default_nettype wire

>>> rtl/core/salc_tag_ram.sv
`default_nettype none

module salc_tag_ram
    import salc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rd_en,
    input  wire logic [SET_W-1:0] rd_addr,
    output row_t                  rd_data,
    input  wire logic             wr_en,
    input  wire logic [SET_W-1:0] wr_addr,
    input  wire row_t             wr_data
);

    row_t mem [SET_COUNT];
    row_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/core/salc_way_scan.sv
`default_nettype none

module salc_way_scan
    import salc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 kick,
    input  wire tag_t                 tag,
    input  wire row_t                 row,
    input  wire way_mask_t            row_valid,
    input  wire logic [WAY_CNT_W-1:0] ways,
    output scan_res_t                 res
);

    way_t way_reg, way_next;
    logic active_reg, active_next;
    logic done_reg, done_next;
    logic hit_reg, hit_next;
    way_t hit_way_reg, hit_way_next;
    logic free_found_reg, free_found_next;
    way_t free_way_reg, free_way_next;
    way_t victim_reg, victim_next;
    logic last_way;

    assign last_way = (WAY_CNT_W'(way_reg) + WAY_CNT_W'(1)) == ways;

    always_comb
    begin
        way_next        = way_reg;
        active_next     = active_reg;
        done_next       = 1'b0;
        hit_next        = hit_reg;
        hit_way_next    = hit_way_reg;
        free_found_next = free_found_reg;
        free_way_next   = free_way_reg;
        victim_next     = victim_reg;
        if (kick)
        begin
            way_next        = '0;
            active_next     = 1'b1;
            hit_next        = 1'b0;
            free_found_next = 1'b0;
            victim_next     = '0;
        end
        else if (active_reg)
        begin
            if (!hit_reg && row_valid[way_reg] && row.tags[way_reg] == tag)
            begin
                hit_next     = 1'b1;
                hit_way_next = way_reg;
            end
            if (!free_found_reg && !row_valid[way_reg])
            begin
                free_found_next = 1'b1;
                free_way_next   = way_reg;
            end
            if (row.ranks[way_reg] > row.ranks[victim_reg])
            begin
                victim_next = way_reg;
            end
            if (last_way)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
            else
            begin
                way_next = way_reg + way_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            way_reg        <= '0;
            active_reg     <= 1'b0;
            done_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            hit_way_reg    <= '0;
            free_found_reg <= 1'b0;
            free_way_reg   <= '0;
            victim_reg     <= '0;
        end
        else
        begin
            way_reg        <= way_next;
            active_reg     <= active_next;
            done_reg       <= done_next;
            hit_reg        <= hit_next;
            hit_way_reg    <= hit_way_next;
            free_found_reg <= free_found_next;
            free_way_reg   <= free_way_next;
            victim_reg     <= victim_next;
        end
    end

    assign res.done       = done_reg;
    assign res.hit        = hit_reg;
    assign res.hit_way    = hit_way_reg;
    assign res.free_found = free_found_reg;
    assign res.free_way   = free_way_reg;
    assign res.victim_way = victim_reg;

endmodule

`default_nettype wire

>>> rtl/core/set_assoc_cache_lru_tags_unit.sv
`default_nettype none

// Tag-only set-associative cache with least-recently-used replacement.
// Command channel: kind and address are taken at a clock edge where start is
// high and busy is low. A load/store gives one result, a modify gives two
// (the second with last set), an instruction fetch gives none and leaves the
// block free at once.
// Result channel: strobe is high for one cycle with hit, miss, evicted, last
// and the saturating hit, miss and eviction totals; the receiver cannot stall
// it, so each result is a transfer in the cycle it is shown.
// Timing: an access reads one set row from the tag memory, then takes one way
// per cycle of the ways in use through the shared tag comparator, then writes
// the row back; a modify does this twice. busy drops in the cycle strobe
// rises, so the next command can be taken then.
// Configuration: cfg_write, cfg_index and cfg_data write set_bits, block_bits
// or ways_in_use; the user must write only while busy is low, unenforced.
// Reset: all lines invalid, totals zero, configuration back to 4, 4 and 4;
// the block is ready in the first cycle after reset.

module set_assoc_cache_lru_tags_unit
    import salc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [KIND_W-1:0]     kind,
    input  wire logic [ADDR_W-1:0]     address,
    output logic                       busy,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       strobe,
    output logic                       hit,
    output logic                       miss,
    output logic                       evicted,
    output logic                       last,
    output logic [CNT_W-1:0]           hit_total,
    output logic [CNT_W-1:0]           miss_total,
    output logic [CNT_W-1:0]           eviction_total
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SCAN
    } state_t;

    state_t state_reg, state_next;
    logic busy_reg, busy_next;
    logic second_reg, second_next;
    tag_t tag_reg, tag_next;
    logic [SET_W-1:0] set_reg, set_next;
    logic [WAY_CNT_W-1:0] ways_reg, ways_next;
    logic strobe_reg, strobe_next;
    logic hit_reg, hit_next;
    logic miss_reg, miss_next;
    logic evicted_reg, evicted_next;
    logic last_reg, last_next;
    logic [CNT_W-1:0] hits_reg, hits_next;
    logic [CNT_W-1:0] misses_reg, misses_next;
    logic [CNT_W-1:0] evictions_reg, evictions_next;

    logic [SET_BITS_W-1:0] set_bits_reg;
    logic [BLOCK_BITS_W-1:0] block_bits_reg;
    logic [WAYS_CFG_W-1:0] ways_cfg_reg;

    way_mask_t valid_reg [SET_COUNT];

    logic [SET_BITS_W-1:0] s_eff;
    logic [BLOCK_BITS_W-1:0] b_eff;
    logic [WAY_CNT_W-1:0] e_eff;
    logic [SHIFT_W-1:0] sb;
    logic [ADDR_W-1:0] set_shift;
    logic [SET_W:0] set_pow;
    logic [SET_W-1:0] set_mask;
    tag_t tag_calc;
    logic [SET_W-1:0] set_calc;

    logic ram_rd_en;
    logic ram_wr_en;
    row_t rd_row;
    row_t new_row;
    scan_res_t scan_res;
    logic scan_kick;
    way_mask_t set_valid;
    way_mask_t new_valid;
    way_t pick;
    logic fill;
    rank_t old_rank;
    logic accept;

    always_comb
    begin
        if (set_bits_reg == '0)
        begin
            s_eff = SET_BITS_W'(1);
        end
        else if (int'(set_bits_reg) > MAX_SET_BITS)
        begin
            s_eff = SET_BITS_W'(MAX_SET_BITS);
        end
        else
        begin
            s_eff = set_bits_reg;
        end
        b_eff = (block_bits_reg == '0) ? BLOCK_BITS_W'(1) : block_bits_reg;
        if (ways_cfg_reg == '0)
        begin
            e_eff = WAY_CNT_W'(1);
        end
        else if (int'(ways_cfg_reg) > WAYS)
        begin
            e_eff = WAY_CNT_W'(WAYS);
        end
        else
        begin
            e_eff = WAY_CNT_W'(ways_cfg_reg);
        end
        sb        = SHIFT_W'(s_eff) + SHIFT_W'(b_eff);
        tag_calc  = TAG_W'(address >> sb);
        set_shift = address >> b_eff;
        set_pow   = (SET_W + 1)'(1) << s_eff;
        set_mask  = SET_W'(set_pow - (SET_W + 1)'(1));
        set_calc  = SET_W'(set_shift) & set_mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= SET_BITS_W'(4);
            block_bits_reg <= BLOCK_BITS_W'(4);
            ways_cfg_reg   <= WAYS_CFG_W'(4);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SET_BITS:   set_bits_reg   <= cfg_data[SET_BITS_W-1:0];
                REG_BLOCK_BITS: block_bits_reg <= cfg_data[BLOCK_BITS_W-1:0];
                REG_WAYS:       ways_cfg_reg   <= cfg_data[WAYS_CFG_W-1:0];
                default:        ;
            endcase
        end
    end

    assign set_valid = valid_reg[set_reg];
    assign pick = scan_res.hit ? scan_res.hit_way :
                  (scan_res.free_found ? scan_res.free_way : scan_res.victim_way);
    assign fill = !scan_res.hit && scan_res.free_found;
    assign old_rank = rd_row.ranks[pick];

    always_comb
    begin
        new_row = rd_row;
        for (int k = 0; k < WAYS; k++)
        begin
            if (WAY_CNT_W'(k) < ways_reg && set_valid[k] && rd_row.ranks[k] != RANK_MAX)
            begin
                if (fill)
                begin
                    new_row.ranks[k] = rd_row.ranks[k] + rank_t'(1);
                end
                else if (way_t'(k) != pick && rd_row.ranks[k] < old_rank)
                begin
                    new_row.ranks[k] = rd_row.ranks[k] + rank_t'(1);
                end
            end
        end
        new_row.ranks[pick] = '0;
        if (!scan_res.hit)
        begin
            new_row.tags[pick] = tag_reg;
        end
        new_valid = set_valid;
        if (fill)
        begin
            new_valid[pick] = 1'b1;
        end
    end

    assign accept = start && !busy_reg;

    always_comb
    begin
        state_next     = state_reg;
        second_next    = second_reg;
        tag_next       = tag_reg;
        set_next       = set_reg;
        ways_next      = ways_reg;
        strobe_next    = 1'b0;
        hit_next       = hit_reg;
        miss_next      = miss_reg;
        evicted_next   = evicted_reg;
        last_next      = last_reg;
        hits_next      = hits_reg;
        misses_next    = misses_reg;
        evictions_next = evictions_reg;
        ram_rd_en      = 1'b0;
        ram_wr_en      = 1'b0;
        scan_kick      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (kind == KIND_ACCESS || kind == KIND_MODIFY))
                begin
                    state_next  = ST_LOOK;
                    second_next = (kind == KIND_MODIFY);
                    tag_next    = tag_calc;
                    set_next    = set_calc;
                    ways_next   = e_eff;
                end
            end
            ST_LOOK:
            begin
                ram_rd_en  = 1'b1;
                scan_kick  = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_res.done)
                begin
                    ram_wr_en    = 1'b1;
                    strobe_next  = 1'b1;
                    hit_next     = scan_res.hit;
                    miss_next    = !scan_res.hit;
                    evicted_next = !scan_res.hit && !scan_res.free_found;
                    last_next    = !second_reg;
                    if (scan_res.hit)
                    begin
                        if (hits_reg != '1)
                        begin
                            hits_next = hits_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        if (misses_reg != '1)
                        begin
                            misses_next = misses_reg + CNT_W'(1);
                        end
                        if (!scan_res.free_found && evictions_reg != '1)
                        begin
                            evictions_next = evictions_reg + CNT_W'(1);
                        end
                    end
                    if (second_reg)
                    begin
                        second_next = 1'b0;
                        state_next  = ST_LOOK;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        busy_next = (state_next != ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            busy_reg      <= 1'b0;
            second_reg    <= 1'b0;
            tag_reg       <= '0;
            set_reg       <= '0;
            ways_reg      <= WAY_CNT_W'(1);
            strobe_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            miss_reg      <= 1'b0;
            evicted_reg   <= 1'b0;
            last_reg      <= 1'b0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            evictions_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            second_reg    <= second_next;
            tag_reg       <= tag_next;
            set_reg       <= set_next;
            ways_reg      <= ways_next;
            strobe_reg    <= strobe_next;
            hit_reg       <= hit_next;
            miss_reg      <= miss_next;
            evicted_reg   <= evicted_next;
            last_reg      <= last_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            evictions_reg <= evictions_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SET_COUNT; i++)
            begin
                valid_reg[i] <= '0;
            end
        end
        else if (ram_wr_en)
        begin
            valid_reg[set_reg] <= new_valid;
        end
    end

    salc_tag_ram u_tag_ram (
        .clk     (clk),
        .rd_en   (ram_rd_en),
        .rd_addr (set_reg),
        .rd_data (rd_row),
        .wr_en   (ram_wr_en),
        .wr_addr (set_reg),
        .wr_data (new_row)
    );

    salc_way_scan u_way_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .kick      (scan_kick),
        .tag       (tag_reg),
        .row       (rd_row),
        .row_valid (set_valid),
        .ways      (ways_reg),
        .res       (scan_res)
    );

    assign busy           = busy_reg;
    assign strobe         = strobe_reg;
    assign hit            = hit_reg;
    assign miss           = miss_reg;
    assign evicted        = evicted_reg;
    assign last           = last_reg;
    assign hit_total      = hits_reg;
    assign miss_total     = misses_reg;
    assign eviction_total = evictions_reg;

endmodule

`default_nettype wire
